// File: sv/imu_bias_observer_step_core_assert.svh
// Assertion macros for the checker file imu_bias_chk.
`ifndef IMU_BIAS_OBSERVER_STEP_CORE_ASSERT_SVH
`define IMU_BIAS_OBSERVER_STEP_CORE_ASSERT_SVH

// clocked check, disabled while reset is asserted
`define IBO_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("imu bias observer: check failed");

// clocked check that also runs during reset
`define IBO_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("imu bias observer: check failed");

`endif

// File: sv/imu_bias_pkg.sv
// ----------------------------------------------------------------------------
// imu_bias_pkg
// Register indexes, sequencer codes and fixed-point constants of the IMU
// bias observer.
// ----------------------------------------------------------------------------
package imu_bias_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_GAIN_ACC_ERR   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_ACC_BIAS  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_RATE_BIAS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_OFS_BIAS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE      = 3'd4;

  localparam logic [31:0] STEP_SIZE_RST = 32'd4294967;
  localparam logic [8:0]  SEQ_RST       = 9'd500;
  localparam logic [8:0]  SEQ_IDLE_ABV  = 9'd200;
  localparam logic [8:0]  GAP_LOST_BLW  = 9'd127;
  localparam logic [8:0]  GAP_LOST_ABV  = 9'd1;

  localparam int unsigned FracShift = 24;
  localparam int unsigned GainShift = 16;
  localparam int unsigned StepShift = 32;

  localparam int unsigned StW = 3;
  localparam logic [StW-1:0] ST_IDLE  = 3'd0;
  localparam logic [StW-1:0] ST_DA    = 3'd1;
  localparam logic [StW-1:0] ST_CROSS = 3'd2;
  localparam logic [StW-1:0] ST_GAIN  = 3'd3;
  localparam logic [StW-1:0] ST_EUL   = 3'd4;
  localparam logic [StW-1:0] ST_DONE  = 3'd5;

  // cross product groups
  localparam logic [2:0] GRP_W_E   = 3'd0;
  localparam logic [2:0] GRP_W_BA  = 3'd1;
  localparam logic [2:0] GRP_A_BW  = 3'd2;
  localparam logic [2:0] GRP_W_DA  = 3'd3;
  localparam logic [2:0] GRP_A_DA  = 3'd4;
  // gain and integration groups
  localparam logic [2:0] GRP_EST   = 3'd0;
  localparam logic [2:0] GRP_BACC  = 3'd1;
  localparam logic [2:0] GRP_BRATE = 3'd2;
  localparam logic [2:0] GRP_BOFS  = 3'd3;

endpackage

// File: sv/imu_bias_observer_step_core.sv
// ----------------------------------------------------------------------------
// imu_bias_observer_step_core
// One Euler step of the IMU bias observer per packet up to sequence 200, with
// lost-packet detection, on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid_i / in_ready_o  accel, rate, sequence_req
//  out       output     out_valid_o / out_ready_i biases, lost_flag, gap
//  cfg       input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
//  Running packet: the DA pass, then the cross, gain and Euler passes,
//  which together put 54 products through the single multiplier.
//  Idle packet (sequence above 200): the estimate takes the accel sample, no step.
//  in_ready_o is high only when the sequencer is idle; a held result stalls
//  the step that finishes the next packet. No clearing pass after reset.
// ----------------------------------------------------------------------------
module imu_bias_observer_step_core import imu_bias_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  accel_x_i,
  input  logic signed [31:0]  accel_y_i,
  input  logic signed [31:0]  accel_z_i,
  input  logic signed [31:0]  rate_x_i,
  input  logic signed [31:0]  rate_y_i,
  input  logic signed [31:0]  rate_z_i,
  input  logic [7:0]          sequence_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  acc_bias_x_o,
  output logic signed [31:0]  acc_bias_y_o,
  output logic signed [31:0]  acc_bias_z_o,
  output logic signed [31:0]  rate_bias_x_o,
  output logic signed [31:0]  rate_bias_y_o,
  output logic signed [31:0]  rate_bias_z_o,
  output logic signed [31:0]  offset_bias_x_o,
  output logic signed [31:0]  offset_bias_y_o,
  output logic signed [31:0]  offset_bias_z_o,
  output logic                lost_flag_o,
  output logic [8:0]          gap_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned MA = ((DW > 32) ? DW : 32) + 1;
  localparam int unsigned PW = MA + DW;
  localparam int unsigned WW = PW + 2;
  localparam int unsigned AW = DW + 4;

  typedef logic signed [DW-1:0] val_t;

  function automatic val_t sat_dw(input logic signed [WW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[WW-1:DW-1];
    hi_zeros = ~|v[WW-1:DW-1];
    if (hi_ones || hi_zeros) begin
      return v[DW-1:0];
    end else if (v[WW-1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [WW-1:0] ext_dw(input val_t v);
    return {{(WW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [WW-1:0] ext_pw(input logic signed [PW-1:0] v);
    return {{(WW-PW){v[PW-1]}}, v};
  endfunction

  function automatic logic signed [WW-1:0] ext_aw(input logic signed [AW-1:0] v);
    return {{(WW-AW){v[AW-1]}}, v};
  endfunction

  function automatic logic signed [AW-1:0] acc_dw(input val_t v);
    return {{(AW-DW){v[DW-1]}}, v};
  endfunction

  function automatic val_t sat_in(input logic signed [31:0] v);
    return sat_dw({{(WW-32){v[31]}}, v});
  endfunction

  function automatic logic [31:0] to_out(input val_t v);
    logic signed [WW-1:0] t;
    t = ext_dw(v);
    return t[31:0];
  endfunction

  // configuration
  logic [31:0] gain_q [4];
  logic [31:0] step_q;

  // architectural state
  logic [8:0] prev_seq_q;
  val_t est_q  [3];
  val_t bacc_q [3];
  val_t brate_q[3];
  val_t bofs_q [3];

  // working registers
  val_t a_q [3];
  val_t w_q [3];
  val_t da_q[3];
  val_t cw_q[3];
  val_t ca_q[3];
  val_t dba_q[3];
  val_t dbw_q[3];
  val_t dbz_q[3];
  logic signed [AW-1:0] acc_q[3];
  logic signed [PW-1:0] tmp_q;
  logic signed [PW-1:0] prod_q;

  logic [StW-1:0] state_q, state_d;
  logic [2:0] grp_q;
  logic [1:0] comp_q;
  logic       half_q;
  logic       ph_q;
  logic       lost_q;
  logic [8:0] gap_q;

  logic out_valid_q;
  logic [31:0] out_q[9];
  logic out_lost_q;
  logic [8:0] out_gap_q;

  logic in_acc;
  logic [8:0] num;
  logic [8:0] gap_w;
  logic [1:0] jj, kk;
  logic [1:0] ui, vi;
  val_t u_sel, v_sel, b_sel;
  logic signed [MA-1:0] opa;
  logic signed [DW-1:0] opb;
  logic signed [PW-1:0] p24, p16, p32;
  val_t cross_w;
  val_t de_w;
  logic last_comp;
  logic finish;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign num        = {1'b0, sequence_req_i};
  assign gap_w      = (prev_seq_q > num) ? (prev_seq_q - num) : (num - prev_seq_q);

  assign jj = (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
  assign kk = (comp_q == 2'd0) ? 2'd2 : comp_q - 2'd1;
  assign ui = half_q ? kk : jj;
  assign vi = half_q ? jj : kk;

  always_comb begin
    if (grp_q == GRP_A_BW || grp_q == GRP_A_DA) begin
      u_sel = a_q[ui];
    end else begin
      u_sel = w_q[ui];
    end
    case (grp_q)
      GRP_W_E:  v_sel = est_q[vi];
      GRP_W_BA: v_sel = bacc_q[vi];
      GRP_A_BW: v_sel = brate_q[vi];
      default:  v_sel = da_q[vi];
    endcase
  end

  assign de_w = sat_dw(ext_aw(acc_q[comp_q]));

  always_comb begin
    opa = {{(MA-DW){u_sel[DW-1]}}, u_sel};
    opb = v_sel;
    b_sel = da_q[comp_q];
    if (state_q == ST_GAIN) begin
      case (grp_q)
        GRP_BACC:  b_sel = cw_q[comp_q];
        GRP_BRATE: b_sel = ca_q[comp_q];
        default:   b_sel = da_q[comp_q];
      endcase
      opa = {{(MA-32){1'b0}}, gain_q[grp_q[1:0]]};
      opb = b_sel;
    end else if (state_q == ST_EUL) begin
      case (grp_q)
        GRP_EST:   b_sel = de_w;
        GRP_BACC:  b_sel = dba_q[comp_q];
        GRP_BRATE: b_sel = dbw_q[comp_q];
        default:   b_sel = dbz_q[comp_q];
      endcase
      opa = {{(MA-32){1'b0}}, step_q};
      opb = b_sel;
    end
  end

  assign p24 = prod_q >>> FracShift;
  assign p16 = prod_q >>> GainShift;
  assign p32 = prod_q >>> StepShift;
  assign cross_w = sat_dw(ext_pw(tmp_q) - ext_pw(p24));
  assign last_comp = (comp_q == 2'd2);
  assign finish = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (num > SEQ_IDLE_ABV) ? ST_DONE : ST_DA;
        end
      end
      ST_DA:    if (last_comp) state_d = ST_CROSS;
      ST_CROSS: if (ph_q && half_q && last_comp && grp_q == GRP_A_DA) state_d = ST_GAIN;
      ST_GAIN:  if (ph_q && last_comp && grp_q == GRP_BOFS) state_d = ST_EUL;
      ST_EUL:   if (ph_q && last_comp && grp_q == GRP_BOFS) state_d = ST_DONE;
      ST_DONE:  if (finish) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grp_q       <= '0;
      comp_q      <= '0;
      half_q      <= 1'b0;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
      gain_q[0]   <= '0;
      gain_q[1]   <= '0;
      gain_q[2]   <= '0;
      gain_q[3]   <= '0;
      step_q      <= STEP_SIZE_RST;
      prev_seq_q  <= SEQ_RST;
      for (int i = 0; i < 3; i++) begin
        est_q[i]   <= '0;
        bacc_q[i]  <= '0;
        brate_q[i] <= '0;
        bofs_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GAIN_ACC_ERR:   gain_q[0] <= cfg_data_i;
          CFG_GAIN_ACC_BIAS:  gain_q[1] <= cfg_data_i;
          CFG_GAIN_RATE_BIAS: gain_q[2] <= cfg_data_i;
          CFG_GAIN_OFS_BIAS:  gain_q[3] <= cfg_data_i;
          CFG_STEP_SIZE:      step_q    <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          grp_q  <= '0;
          comp_q <= '0;
          half_q <= 1'b0;
          ph_q   <= 1'b0;
          if (in_acc) begin
            prev_seq_q <= num;
            if (num > SEQ_IDLE_ABV) begin
              est_q[0] <= sat_in(accel_x_i);
              est_q[1] <= sat_in(accel_y_i);
              est_q[2] <= sat_in(accel_z_i);
            end
          end
        end
        ST_DA: begin
          comp_q <= last_comp ? 2'd0 : comp_q + 2'd1;
        end
        ST_CROSS: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            half_q <= ~half_q;
            if (half_q) begin
              comp_q <= last_comp ? 2'd0 : comp_q + 2'd1;
              if (last_comp) grp_q <= (grp_q == GRP_A_DA) ? 3'd0 : grp_q + 3'd1;
            end
          end
        end
        ST_GAIN, ST_EUL: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            comp_q <= last_comp ? 2'd0 : comp_q + 2'd1;
            if (last_comp) grp_q <= (grp_q == GRP_BOFS) ? 3'd0 : grp_q + 3'd1;
            if (state_q == ST_EUL) begin
              case (grp_q)
                GRP_EST:   est_q[comp_q]   <= sat_dw(ext_dw(est_q[comp_q]) + ext_pw(p32));
                GRP_BACC:  bacc_q[comp_q]  <= sat_dw(ext_dw(bacc_q[comp_q]) + ext_pw(p32));
                GRP_BRATE: brate_q[comp_q] <= sat_dw(ext_dw(brate_q[comp_q]) + ext_pw(p32));
                default:   bofs_q[comp_q]  <= sat_dw(ext_dw(bofs_q[comp_q]) + ext_pw(p32));
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q[0] <= sat_in(accel_x_i);
      a_q[1] <= sat_in(accel_y_i);
      a_q[2] <= sat_in(accel_z_i);
      w_q[0] <= sat_in(rate_x_i);
      w_q[1] <= sat_in(rate_y_i);
      w_q[2] <= sat_in(rate_z_i);
      gap_q  <= gap_w;
      lost_q <= (gap_w > GAP_LOST_ABV) && (gap_w < GAP_LOST_BLW);
    end
    case (state_q)
      ST_DA: begin
        da_q[comp_q]  <= sat_dw(ext_dw(est_q[comp_q]) - ext_dw(a_q[comp_q]));
        acc_q[comp_q] <= -acc_dw(bofs_q[comp_q]);
      end
      ST_CROSS: begin
        if (ph_q) begin
          if (!half_q) begin
            tmp_q <= p24;
          end else begin
            case (grp_q)
              GRP_W_E:  acc_q[comp_q] <= acc_q[comp_q] - acc_dw(cross_w);
              GRP_W_BA: acc_q[comp_q] <= acc_q[comp_q] + acc_dw(cross_w);
              GRP_A_BW: acc_q[comp_q] <= acc_q[comp_q] - acc_dw(cross_w);
              GRP_W_DA: cw_q[comp_q]  <= cross_w;
              default:  ca_q[comp_q]  <= cross_w;
            endcase
          end
        end
      end
      ST_GAIN: begin
        if (ph_q) begin
          case (grp_q)
            GRP_EST:   acc_q[comp_q] <= acc_q[comp_q] - acc_dw(sat_dw(ext_pw(p16)));
            GRP_BACC:  dba_q[comp_q] <= sat_dw(ext_pw(p16));
            GRP_BRATE: dbw_q[comp_q] <= sat_dw(-ext_pw(p16));
            default:   dbz_q[comp_q] <= sat_dw(ext_pw(p16));
          endcase
        end
      end
      ST_DONE: begin
        if (finish) begin
          out_q[0]   <= to_out(bacc_q[0]);
          out_q[1]   <= to_out(bacc_q[1]);
          out_q[2]   <= to_out(bacc_q[2]);
          out_q[3]   <= to_out(brate_q[0]);
          out_q[4]   <= to_out(brate_q[1]);
          out_q[5]   <= to_out(brate_q[2]);
          out_q[6]   <= to_out(bofs_q[0]);
          out_q[7]   <= to_out(bofs_q[1]);
          out_q[8]   <= to_out(bofs_q[2]);
          out_lost_q <= lost_q;
          out_gap_q  <= gap_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign acc_bias_x_o    = out_q[0];
  assign acc_bias_y_o    = out_q[1];
  assign acc_bias_z_o    = out_q[2];
  assign rate_bias_x_o   = out_q[3];
  assign rate_bias_y_o   = out_q[4];
  assign rate_bias_z_o   = out_q[5];
  assign offset_bias_x_o = out_q[6];
  assign offset_bias_y_o = out_q[7];
  assign offset_bias_z_o = out_q[8];
  assign lost_flag_o     = out_lost_q;
  assign gap_o           = out_gap_q;

endmodule

// File: sv/imu_bias_chk.sv
// ----------------------------------------------------------------------------
// imu_bias_chk
// Port-level checks of the IMU bias observer, bound to the top level.
// ----------------------------------------------------------------------------
`include "imu_bias_observer_step_core_assert.svh"

module imu_bias_chk import imu_bias_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       lost_flag_o,
  input logic [8:0] gap_o
);

  `IBO_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  `IBO_ASSERT(a_gap_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(gap_o))
  `IBO_ASSERT(a_busy_after_txn, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `IBO_ASSERT(a_lost_range, clk_i, rst_ni,
    out_valid_o && lost_flag_o |-> (gap_o > GAP_LOST_ABV) && (gap_o < GAP_LOST_BLW))

endmodule

bind imu_bias_observer_step_core imu_bias_chk u_imu_bias_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .lost_flag_o (lost_flag_o),
  .gap_o       (gap_o)
);

// File: tb/tb_imu_bias_observer_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_bias_observer_step_core
// Drives IMU packets through the bias observer step under random idle gaps
// and backpressure. A cycle-free model of the observer predicts each result,
// and a monitor compares every output transaction field by field.
// ----------------------------------------------------------------------------
module tb_imu_bias_observer_step_core import imu_bias_pkg::*; ();

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_SPARE = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0][31:0] acc_bias;
    logic [2:0][31:0] rate_bias;
    logic [2:0][31:0] ofs_bias;
    logic             lost;
    logic [8:0]       gap;
  } bias_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic signed [31:0] rate_x_i = '0, rate_y_i = '0, rate_z_i = '0;
  logic [7:0] sequence_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] acc_bias_x_o, acc_bias_y_o, acc_bias_z_o;
  logic signed [31:0] rate_bias_x_o, rate_bias_y_o, rate_bias_z_o;
  logic signed [31:0] offset_bias_x_o, offset_bias_y_o, offset_bias_z_o;
  logic lost_flag_o;
  logic [8:0] gap_o;

  imu_bias_observer_step_core dut (.*);

  always #10 clk_i = ~clk_i;

  // observer model state
  longint est[3], bacc[3], brate[3], bofs[3];
  longint k1, k2, k3, k4, dt;
  int unsigned prev_seq;

  bias_rec_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned packets_sent = 0;
  int unsigned running_packets = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  int unsigned hold_req = 0;
  int unsigned stall_cnt = 0;
  int unsigned seq_cur = 0;

  function automatic longint sat(longint v);
    return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(2);
    if (r < 95) return $urandom_range(10, 3);
    return $urandom_range(150, 20);
  endfunction

  function automatic void model_reset();
    k1 = 0; k2 = 0; k3 = 0; k4 = 0;
    dt = longint'(STEP_SIZE_RST);
    prev_seq = 32'(SEQ_RST);
    for (int i = 0; i < 3; i++) begin
      est[i] = 0; bacc[i] = 0; brate[i] = 0; bofs[i] = 0;
    end
  endfunction

  function automatic longint xprod(longint uj, longint vk, longint uk, longint vj);
    return sat(((uj * vk) >>> FracShift) - ((uk * vj) >>> FracShift));
  endfunction

  function automatic bias_rec_t observer_step(longint a[3], longint w[3], int unsigned num);
    bias_rec_t r;
    longint da[3], c1[3], c2[3], c3[3], cw[3], ca[3];
    longint de[3], dba[3], dbw[3], dbz[3];
    int unsigned g;
    int j, k;
    g = prev_seq > num ? prev_seq - num : num - prev_seq;
    g &= 9'h1FF;
    r.gap = g[8:0];
    r.lost = (g > GAP_LOST_ABV) && (g < GAP_LOST_BLW);
    prev_seq = num;
    if (num > SEQ_IDLE_ABV) begin
      for (int i = 0; i < 3; i++) est[i] = a[i];
    end else begin
      running_packets++;
      for (int i = 0; i < 3; i++) da[i] = sat(est[i] - a[i]);
      for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        c1[i] = xprod(w[j], est[k], w[k], est[j]);
        c2[i] = xprod(w[j], bacc[k], w[k], bacc[j]);
        c3[i] = xprod(a[j], brate[k], a[k], brate[j]);
        cw[i] = xprod(w[j], da[k], w[k], da[j]);
        ca[i] = xprod(a[j], da[k], a[k], da[j]);
      end
      for (int i = 0; i < 3; i++) begin
        de[i] = sat(-c1[i] + c2[i] - c3[i] - bofs[i] - sat((k1 * da[i]) >>> GainShift));
        dba[i] = sat((k2 * cw[i]) >>> GainShift);
        dbw[i] = sat(-((k3 * ca[i]) >>> GainShift));
        dbz[i] = sat((k4 * da[i]) >>> GainShift);
      end
      for (int i = 0; i < 3; i++) begin
        est[i] = sat(est[i] + ((dt * de[i]) >>> StepShift));
        bacc[i] = sat(bacc[i] + ((dt * dba[i]) >>> StepShift));
        brate[i] = sat(brate[i] + ((dt * dbw[i]) >>> StepShift));
        bofs[i] = sat(bofs[i] + ((dt * dbz[i]) >>> StepShift));
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.acc_bias[i] = bacc[i][31:0];
      r.rate_bias[i] = brate[i][31:0];
      r.ofs_bias[i] = bofs[i][31:0];
    end
    return r;
  endfunction

  // transaction on the packet channel
  task automatic send_packet(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                             logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                             logic [7:0] seq);
    int unsigned gap;
    longint a[3], w[3];
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i <= ax; accel_y_i <= ay; accel_z_i <= az;
    rate_x_i <= wx; rate_y_i <= wy; rate_z_i <= wz;
    sequence_req_i <= seq;
    do @(posedge clk_i); while (!in_ready_o);
    a[0] = longint'(signed'(ax)); a[1] = longint'(signed'(ay));
    a[2] = longint'(signed'(az));
    w[0] = longint'(signed'(wx)); w[1] = longint'(signed'(wy));
    w[2] = longint'(signed'(wz));
    expected_q.push_back(observer_step(a, w, {24'd0, seq}));
    packets_sent++;
    seq_cur = {24'd0, seq};
  endtask

  task automatic release_channel();
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (130) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_GAIN_ACC_ERR:   k1 = longint'(val);
      CFG_GAIN_ACC_BIAS:  k2 = longint'(val);
      CFG_GAIN_RATE_BIAS: k3 = longint'(val);
      CFG_GAIN_OFS_BIAS:  k4 = longint'(val);
      CFG_STEP_SIZE:      dt = longint'(val);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_gains(logic [31:0] g1, logic [31:0] g2, logic [31:0] g3,
                           logic [31:0] g4, logic [31:0] step);
    release_channel();
    write_reg(CFG_GAIN_ACC_ERR, g1);
    write_reg(CFG_GAIN_ACC_BIAS, g2);
    write_reg(CFG_GAIN_RATE_BIAS, g3);
    write_reg(CFG_GAIN_OFS_BIAS, g4);
    write_reg(CFG_STEP_SIZE, step);
  endtask

  function automatic logic [31:0] rand_q824();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return 32'(signed'($urandom_range(200000000)) - 100000000);
    if (r < 8) return $urandom();
    return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  function automatic logic [7:0] next_seq();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return 8'(seq_cur + 1) > 8'(SEQ_IDLE_ABV) ? 8'd0 : 8'(seq_cur + 1);
    if (r < 85) return 8'(seq_cur + $urandom_range(126, 2));
    if (r < 92) return 8'($urandom_range(255, 201));
    return 8'($urandom());
  endfunction

  task automatic test_directed();
    send_packet(32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'd0);
    send_packet(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd1);
    send_packet(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd3);
    send_packet(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'd129);
    send_packet(32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0, 8'd2);
    send_packet(32'h0200_0000, 32'h0, 32'hFF00_0000, 32'h0010_0000, 32'h0, 32'h0,
                8'd200);
    send_packet(32'h0300_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'd201);
    send_packet(32'h0, 32'h0100_0000, 32'h0, 32'h0, 32'h0020_0000, 32'h0, 8'd75);
    send_packet(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'd255);
    send_packet(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'd128);
    set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED, 32'h0);
    write_reg(CFG_FIRST_SPARE, 32'h1234_5678);
    for (int i = 0; i < 6; i++)
      send_packet(rand_q824(), rand_q824(), rand_q824(), rand_q824(), rand_q824(),
                  rand_q824(), 8'(i * 40));
    set_gains(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_packet(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd10);
  endtask

  task automatic test_random_phase(int unsigned n);
    for (int i = 0; i < n; i++)
      send_packet(rand_q824(), rand_q824(), rand_q824(), rand_q824(), rand_q824(),
                  rand_q824(), next_seq());
  endtask

  task automatic test_no_idle(int unsigned n);
    quiet = 1'b1;
    test_random_phase(n);
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req = 3000;
    test_random_phase(20);
  endtask

  // receiver ready with random stalls
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      stall_cnt = hold_req;
      hold_req = 0;
    end
    if (stall_cnt > 0) begin
      out_ready_i <= 1'b0;
      stall_cnt--;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet && $urandom_range(7) == 0) stall_cnt = idle_len();
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    bias_rec_t e, got;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      got.acc_bias = {acc_bias_z_o, acc_bias_y_o, acc_bias_x_o};
      got.rate_bias = {rate_bias_z_o, rate_bias_y_o, rate_bias_x_o};
      got.ofs_bias = {offset_bias_z_o, offset_bias_y_o, offset_bias_x_o};
      got.lost = lost_flag_o;
      got.gap = gap_o;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %h", got);
      end else begin
        e = expected_q.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d", results_seen);
            $display("  acc_bias  exp %h got %h", e.acc_bias, got.acc_bias);
            $display("  rate_bias exp %h got %h", e.rate_bias, got.rate_bias);
            $display("  ofs_bias  exp %h got %h", e.ofs_bias, got.ofs_bias);
            $display("  lost/gap  exp %b/%0d got %b/%0d", e.lost, e.gap, got.lost, got.gap);
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_2000, STEP_SIZE_RST);
    test_random_phase(300);
    test_backpressure();
    set_gains(32'hFFFF_FFFF, 32'h0100_0000, 32'h0010_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    test_random_phase(280);
    test_no_idle(60);
    set_gains($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    test_random_phase(280);
    set_gains(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    test_random_phase(200);
    set_gains(32'h0002_0000, 32'h0004_0000, 32'h0001_0000, 32'h0000_1000, 32'h0100_0000);
    test_random_phase(280);
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d packets sent, %0d with an observer step, %0d results checked",
             packets_sent, running_packets, results_seen);
    $display("gain settings from zero to full scale, mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
